// ----- design/pve_pkg.sv -----
// Shared types and constants for the pose velocity estimator.
// Holds the widths, the micro-op and jump codes and the control structs.
// No dependencies; compile first.
package pve_pkg;

  localparam int AXES       = 3;
  localparam int POS_W      = 32;
  localparam int TIME_W     = 48;
  localparam int DT_W       = TIME_W - 1;
  localparam int DIFF_W     = POS_W + 1;
  localparam int SCALE_W    = 20;
  localparam int PROD_W     = DIFF_W + SCALE_W;
  localparam int CNT_W      = $clog2(PROD_W + 1);
  localparam int BLEND_W    = 17;
  localparam int BLEND_FRAC = 16;
  localparam int BPROD_W    = DIFF_W + BLEND_W;
  localparam int STATUS_W   = 2;
  localparam int STEP_W     = 4;

  localparam logic [SCALE_W-1:0]  SCALE       = SCALE_W'(1000000);
  localparam logic [BLEND_W-1:0]  BLEND_ONE   = BLEND_W'(65536);
  localparam logic [BLEND_W-1:0]  BLEND_RESET = BLEND_W'(6554);
  localparam logic [BPROD_W-1:0]  BLEND_HALF  = BPROD_W'(32768);
  localparam logic [POS_W-1:0]    POS_MAX     = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [POS_W-1:0]    POS_MIN     = {1'b1, {(POS_W-1){1'b0}}};

  localparam logic [STATUS_W-1:0] VS_FIRST    = 2'd0;
  localparam logic [STATUS_W-1:0] VS_COMPUTED = 2'd1;
  localparam logic [STATUS_W-1:0] VS_HELD     = 2'd2;

  typedef enum logic [3:0] {
    OP_NOP    = 4'd0,
    OP_WAIT   = 4'd1,
    OP_SETUP  = 4'd2,
    OP_DIVIDE = 4'd3,
    OP_CLIP   = 4'd4,
    OP_BMUL   = 4'd5,
    OP_BADD   = 4'd6,
    OP_ZERO   = 4'd7,
    OP_HOLD   = 4'd8,
    OP_EMIT   = 4'd9
  } uop_t;

  typedef enum logic [2:0] {
    COND_NEVER    = 3'd0,
    COND_ALWAYS   = 3'd1,
    COND_NO_INPUT = 3'd2,
    COND_FIRST    = 3'd3,
    COND_HOLD     = 3'd4,
    COND_DIV_MORE = 3'd5,
    COND_OUT_BUSY = 3'd6
  } cond_t;

  typedef struct packed {
    uop_t              op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic in_valid;
    logic first;
    logic hold;
    logic out_busy;
  } seq_flags_t;

endpackage

// ----- design/pve_if.sv -----
// Valid/ready channel interfaces for sample words and result words.
// Depends on pve_pkg for field widths.
interface pve_sample_if;
  import pve_pkg::*;
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  meas_x;
  logic [POS_W-1:0]  meas_y;
  logic [POS_W-1:0]  meas_z;
  logic [TIME_W-1:0] sample_time_us;

  modport source (output valid, meas_x, meas_y, meas_z, sample_time_us, input ready);
  modport sink   (input valid, meas_x, meas_y, meas_z, sample_time_us, output ready);
endinterface

interface pve_result_if;
  import pve_pkg::*;
  logic                valid;
  logic                ready;
  logic [POS_W-1:0]    pos_out_x;
  logic [POS_W-1:0]    pos_out_y;
  logic [POS_W-1:0]    pos_out_z;
  logic [POS_W-1:0]    vel_out_x;
  logic [POS_W-1:0]    vel_out_y;
  logic [POS_W-1:0]    vel_out_z;
  logic [TIME_W-1:0]   time_out_us;
  logic [STATUS_W-1:0] vel_status;
  logic                vel_saturated;

  modport source (output valid, pos_out_x, pos_out_y, pos_out_z, vel_out_x, vel_out_y,
                  vel_out_z, time_out_us, vel_status, vel_saturated, input ready);
  modport sink   (input valid, pos_out_x, pos_out_y, pos_out_z, vel_out_x, vel_out_y,
                  vel_out_z, time_out_us, vel_status, vel_saturated, output ready);
endinterface

// ----- design/pve_seq.sv -----
// Microcode sequencer: program ROM, step counter, divide bit counter.
// Depends on pve_pkg.
module pve_seq import pve_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  seq_flags_t flags,
  output uop_t       op
);

  localparam logic [STEP_W-1:0] STEP_WAIT  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_DIV   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_ZERO  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_HOLD  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_EMIT  = 4'd9;
  localparam logic [STEP_W-1:0] STEP_LAST  = 4'd10;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic [CNT_W-1:0]  div_count;
  ctrl_word_t        word;
  logic              take;

  always_comb begin
    case (step)
      4'd0:    word = '{OP_WAIT,   COND_NO_INPUT, STEP_WAIT};
      4'd1:    word = '{OP_NOP,    COND_FIRST,    STEP_ZERO};
      4'd2:    word = '{OP_SETUP,  COND_HOLD,     STEP_HOLD};
      4'd3:    word = '{OP_DIVIDE, COND_DIV_MORE, STEP_DIV};
      4'd4:    word = '{OP_CLIP,   COND_NEVER,    STEP_WAIT};
      4'd5:    word = '{OP_BMUL,   COND_NEVER,    STEP_WAIT};
      4'd6:    word = '{OP_BADD,   COND_ALWAYS,   STEP_EMIT};
      4'd7:    word = '{OP_ZERO,   COND_ALWAYS,   STEP_EMIT};
      4'd8:    word = '{OP_HOLD,   COND_NEVER,    STEP_WAIT};
      4'd9:    word = '{OP_EMIT,   COND_OUT_BUSY, STEP_EMIT};
      default: word = '{OP_NOP,    COND_ALWAYS,   STEP_WAIT};
    endcase
  end

  always_comb begin
    case (word.cond)
      COND_NEVER:    take = 1'b0;
      COND_ALWAYS:   take = 1'b1;
      COND_NO_INPUT: take = !flags.in_valid;
      COND_FIRST:    take = flags.first;
      COND_HOLD:     take = flags.hold;
      COND_DIV_MORE: take = (div_count != CNT_W'(1));
      COND_OUT_BUSY: take = flags.out_busy;
      default:       take = 1'b0;
    endcase
    step_next = take ? word.target : step + STEP_W'(1);
  end

  assign op = word.op;

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= STEP_WAIT;
      div_count <= '0;
    end else begin
      step <= step_next;
      if (word.op == OP_SETUP) begin
        div_count <= CNT_W'(PROD_W);
      end else if (word.op == OP_DIVIDE) begin
        div_count <= div_count - CNT_W'(1);
      end
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (rst) step <= STEP_LAST)
    else $error("sequencer step outside program");
  a_div_count: assert property (@(posedge clk) disable iff (rst)
    word.op == OP_DIVIDE |-> div_count != '0)
    else $error("divide step with exhausted bit count");
  a_reset_step: assert property (@(posedge clk) $past(rst) |-> step == STEP_WAIT)
    else $error("sequencer not at wait step after reset");

endmodule

// ----- design/pve_lane.sv -----
// One axis datapath: difference, scale, restoring divide, clip and blend, or a zero or held velocity.
// Driven by micro-ops from pve_seq; depends on pve_pkg.
module pve_lane import pve_pkg::*; (
  input  logic               clk,
  input  uop_t               op,
  input  logic [POS_W-1:0]   pos,
  input  logic [POS_W-1:0]   last_pos,
  input  logic [POS_W-1:0]   last_vel,
  input  logic [DT_W-1:0]    dt,
  input  logic [BLEND_W-1:0] blend_a,
  output logic [POS_W-1:0]   vel_new,
  output logic               clip
);

  logic [PROD_W-1:0]  quo;
  logic [DT_W-1:0]    rem;
  logic               neg;
  logic [POS_W-1:0]   raw;
  logic [BPROD_W-1:0] bprod;
  logic               dneg;

  logic [DIFF_W-1:0]  diff;
  logic [DIFF_W-1:0]  mag;
  logic [DT_W:0]      trial;
  logic               ge;
  logic [DT_W:0]      trial_sub;
  logic [PROD_W-1:0]  limit;
  logic               over;
  logic [PROD_W-1:0]  qc;
  logic [DIFF_W-1:0]  d;
  logic [DIFF_W-1:0]  dmag;
  logic [BPROD_W-1:0] rounded;
  logic [DIFF_W-1:0]  stepv;
  logic [DIFF_W-1:0]  blended;

  always_comb begin
    diff      = {pos[POS_W-1], pos} - {last_pos[POS_W-1], last_pos};
    mag       = diff[DIFF_W-1] ? -diff : diff;
    trial     = {rem, quo[PROD_W-1]};
    ge        = trial >= {1'b0, dt};
    trial_sub = trial - {1'b0, dt};
    limit     = neg ? PROD_W'({1'b0, POS_MIN}) : PROD_W'({1'b0, POS_MAX});
    over      = quo > limit;
    qc        = over ? limit : quo;
    d         = {raw[POS_W-1], raw} - {last_vel[POS_W-1], last_vel};
    dmag      = d[DIFF_W-1] ? -d : d;
    rounded   = bprod + BLEND_HALF;
    stepv     = rounded[BLEND_FRAC +: DIFF_W];
    blended   = dneg ? ({last_vel[POS_W-1], last_vel} - stepv)
                     : ({last_vel[POS_W-1], last_vel} + stepv);
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_SETUP: begin
        neg <= diff[DIFF_W-1];
        quo <= PROD_W'(mag) * PROD_W'(SCALE);
        rem <= '0;
      end
      OP_DIVIDE: begin
        rem <= ge ? trial_sub[DT_W-1:0] : trial[DT_W-1:0];
        quo <= {quo[PROD_W-2:0], ge};
      end
      OP_CLIP: begin
        clip <= over;
        raw  <= neg ? -qc[POS_W-1:0] : qc[POS_W-1:0];
      end
      OP_BMUL: begin
        dneg  <= d[DIFF_W-1];
        bprod <= BPROD_W'(dmag) * BPROD_W'(blend_a);
      end
      OP_BADD: vel_new <= blended[POS_W-1:0];
      OP_ZERO: vel_new <= '0;
      OP_HOLD: vel_new <= last_vel;
      default: ;
    endcase
  end

endmodule

// ----- design/pose_velocity_estimator.sv -----
// Pose velocity estimator top: channel registers, filter state, three axis lanes.
// Depends on pve_pkg, pve_if, pve_seq and pve_lane.
//
//   channel   dir  words                                    handshake
//   sample    in   meas_x/y/z, sample_time_us               valid/ready
//   result    out  pos_out_x/y/z, vel_out_x/y/z, time_out_us,
//                  vel_status, vel_saturated                valid/ready
//   cfg       in   blend_factor (17 bit)                    cfg_we/cfg_wdata
//
// A computed word reaches the result register after the setup step, the restoring
// divide over all PROD_W quotient bits that all three lanes run together, and the
// clip and blend steps; a first word goes through the zero step and a held word
// through setup and hold. A spare step after emit returns the sequencer to its
// wait step. The next sample is taken while a result waits.
// rst (synchronous) clears the filter state and returns blend_factor to 6554.
// A stalled result holds the sequencer at its emit step.
module pose_velocity_estimator import pve_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [BLEND_W-1:0]  cfg_wdata,
  pve_sample_if.sink          sample,
  pve_result_if.source        result
);

  logic [BLEND_W-1:0]             blend_factor;
  logic [BLEND_W-1:0]             blend_a;
  logic [AXES-1:0][POS_W-1:0]     pos;
  logic [TIME_W-1:0]              time_in;
  logic [AXES-1:0][POS_W-1:0]     last_pos;
  logic [AXES-1:0][POS_W-1:0]     last_vel;
  logic [TIME_W-1:0]              last_time;
  logic                           awaiting_first;
  logic [DT_W-1:0]                dt;
  logic [STATUS_W-1:0]            status;
  logic                           saturated;

  logic [AXES-1:0][POS_W-1:0]     vel_new;
  logic [AXES-1:0]                clip;
  logic [TIME_W-1:0]              elapsed;
  logic                           out_busy;
  logic [POS_W-1:0]               neg_x;
  logic [POS_W-1:0]               neg_z;
  seq_flags_t                     flags;
  uop_t                           op;

  always_comb begin
    elapsed  = time_in - last_time;
    out_busy = result.valid && !result.ready;
    neg_x    = (sample.meas_x == POS_MIN) ? POS_MAX : -sample.meas_x;
    neg_z    = (sample.meas_z == POS_MIN) ? POS_MAX : -sample.meas_z;
    blend_a  = (blend_factor > BLEND_ONE) ? BLEND_ONE : blend_factor;
    flags.in_valid = sample.valid;
    flags.first    = awaiting_first;
    flags.hold     = (elapsed == '0) || elapsed[TIME_W-1];
    flags.out_busy = out_busy;
  end

  assign sample.ready = (op == OP_WAIT);

  pve_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .op    (op)
  );

  for (genvar i = 0; i < AXES; i++) begin : g_lane
    pve_lane u_lane (
      .clk      (clk),
      .op       (op),
      .pos      (pos[i]),
      .last_pos (last_pos[i]),
      .last_vel (last_vel[i]),
      .dt       (dt),
      .blend_a  (blend_a),
      .vel_new  (vel_new[i]),
      .clip     (clip[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_factor   <= BLEND_RESET;
      awaiting_first <= 1'b1;
      last_pos       <= '0;
      last_vel       <= '0;
      last_time      <= '0;
      result.valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        blend_factor <= cfg_wdata;
      end
      if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      if (op == OP_EMIT && !out_busy) begin
        result.valid   <= 1'b1;
        awaiting_first <= 1'b0;
        last_pos       <= pos;
        last_vel       <= vel_new;
        last_time      <= time_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      pos[0]  <= neg_x;
      pos[1]  <= sample.meas_y;
      pos[2]  <= neg_z;
      time_in <= sample.sample_time_us;
    end
    case (op)
      OP_SETUP: dt <= elapsed[DT_W-1:0];
      OP_BADD: begin
        status    <= VS_COMPUTED;
        saturated <= |clip;
      end
      OP_ZERO: begin
        status    <= VS_FIRST;
        saturated <= 1'b0;
      end
      OP_HOLD: begin
        status    <= VS_HELD;
        saturated <= 1'b0;
      end
      OP_EMIT: begin
        if (!out_busy) begin
          result.pos_out_x     <= pos[0];
          result.pos_out_y     <= pos[1];
          result.pos_out_z     <= pos[2];
          result.vel_out_x     <= vel_new[0];
          result.vel_out_y     <= vel_new[1];
          result.vel_out_z     <= vel_new[2];
          result.time_out_us   <= time_in;
          result.vel_status    <= status;
          result.vel_saturated <= saturated;
        end
      end
      default: ;
    endcase
  end

  a_first_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.vel_status == VS_FIRST |->
      result.vel_out_x == '0 && result.vel_out_y == '0 && result.vel_out_z == '0)
    else $error("first word carries nonzero velocity");
  a_sat_computed: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.vel_status != VS_COMPUTED |-> !result.vel_saturated)
    else $error("saturation flagged on a word without computed velocity");
  a_first_cleared: assert property (@(posedge clk) disable iff (rst)
    $fell(awaiting_first) |-> $past(op == OP_EMIT))
    else $error("first-sample flag cleared outside emit");

endmodule
